// ===== sv/assert_macros.svh =====
// Assertion macros used by the device tree walker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge while reset is released.
`define DTTW_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("device tree walker assertion failed");

// Condition that must never hold at a rising clock edge out of reset.
`define DTTW_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("device tree walker forbidden condition");

`endif

// ===== sv/dttw_pkg.sv =====
// Package with the types and constants of the device tree token walker.
package dttw_pkg;

	localparam int unsigned MAX_DEPTH_DEFAULT = 63;
	localparam int unsigned EVT_FIFO_DEPTH = 3;

	localparam logic [31:0] TAG_BEGIN_NODE = 32'h0000_0001;
	localparam logic [31:0] TAG_END_NODE   = 32'h0000_0002;
	localparam logic [31:0] TAG_PROP       = 32'h0000_0003;
	localparam logic [31:0] TAG_NOP        = 32'h0000_0004;
	localparam logic [31:0] TAG_END        = 32'h0000_0009;

	typedef enum logic [2:0] {
		EV_BEGIN_NODE = 3'd0,
		EV_END_NODE   = 3'd1,
		EV_PROP       = 3'd2,
		EV_NOP        = 3'd3,
		EV_END        = 3'd4,
		EV_BAD_TAG    = 3'd5
	} event_kind_t;

	typedef struct packed {
		event_kind_t kind;
		logic [5:0]  depth;
		logic [31:0] prop_length;
		logic [31:0] name_offset;
		logic [31:0] first_word;
		logic [15:0] node_name_length;
		logic        depth_fault;
	} walk_event_t;

endpackage

// ===== sv/device_tree_token_walker.sv =====
// Top level of the flattened device tree structure block token walker.
//
//  Channel | Beat                     | Handshake
//  --------+--------------------------+---------------------------
//  item    | data_byte, first_byte    | item_valid / item_stall
//  result  | event_kind ... depth_... | result_valid / result_stall
//
// One byte beat is taken per cycle while item_stall is low; it is registered, walked in
// the next cycle, and its event (if any) is written to a three-entry result queue.
// item_stall rises when the queue plus the byte in flight could fill it. Reset clears
// the walker to await a tag at depth zero.
// A stalled result side stops intake once queued events and the byte in flight reach three.
`include "assert_macros.svh"

module device_tree_token_walker #(
	parameter int unsigned MAX_DEPTH = dttw_pkg::MAX_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  event_kind,
	output logic [5:0]  depth,
	output logic [31:0] prop_length,
	output logic [31:0] name_offset,
	output logic [31:0] first_word,
	output logic [15:0] node_name_length,
	output logic        depth_fault
);

	localparam int unsigned CW = $clog2(dttw_pkg::EVT_FIFO_DEPTH + 1);

	logic                  accept;
	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  first_s1;
	logic                  evt_valid;
	dttw_pkg::walk_event_t evt;
	dttw_pkg::walk_event_t head_evt;
	logic [CW-1:0]         fifo_count;
	logic [CW:0]           pending;

	assign pending    = {1'b0, fifo_count} + {{CW{1'b0}}, valid_s1};
	assign item_stall = (pending >= (CW + 1)'(dttw_pkg::EVT_FIFO_DEPTH));
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
		end
	end

	dttw_walker #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.first_s1 (first_s1),
		.evt_valid(evt_valid),
		.evt      (evt)
	);

	dttw_evt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (evt_valid),
		.push_evt  (evt),
		.pop       (!result_stall),
		.head_valid(result_valid),
		.head_evt  (head_evt),
		.count     (fifo_count)
	);

	assign event_kind       = head_evt.kind;
	assign depth            = head_evt.depth;
	assign prop_length      = head_evt.prop_length;
	assign name_offset      = head_evt.name_offset;
	assign first_word       = head_evt.first_word;
	assign node_name_length = head_evt.node_name_length;
	assign depth_fault      = head_evt.depth_fault;

	`DTTW_ASSERT(a_accept_fills_s1, clk, arst_n, accept |=> valid_s1)
	`DTTW_ASSERT(a_event_needs_byte, clk, arst_n, evt_valid |-> valid_s1)
	`DTTW_NEVER(a_no_queue_overflow, clk, arst_n,
		evt_valid && fifo_count == CW'(dttw_pkg::EVT_FIFO_DEPTH))
	`DTTW_ASSERT(a_valid_tracks_count, clk, arst_n, result_valid == (fifo_count != '0))

endmodule

// ===== sv/dttw_walker.sv =====
// Token walker: per-byte phase tracking, tag decode and event building.
module dttw_walker #(
	parameter int unsigned MAX_DEPTH = dttw_pkg::MAX_DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  logic [7:0]           data_s1,
	input  logic                 first_s1,
	output logic                 evt_valid,
	output dttw_pkg::walk_event_t evt
);

	localparam int unsigned NW = $clog2(MAX_DEPTH + 1);
	localparam logic [NW-1:0] NEST_MAX = NW'(MAX_DEPTH);

	typedef enum logic [5:0] {
		PH_TAG     = 6'b000001,
		PH_NAME    = 6'b000010,
		PH_PLEN    = 6'b000100,
		PH_POFF    = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_PAD     = 6'b100000
	} phase_t;

	phase_t        phase_q, e_phase, n_phase;
	logic [1:0]    lane_q, e_lane, n_lane;
	logic [31:0]   wg_q, e_wg, n_wg, wg_shift;
	logic [NW-1:0] nest_q, e_nest, n_nest;
	logic [31:0]   bl_q, e_bl, n_bl, bl_dec;
	logic [31:0]   hl_q, e_hl, n_hl;
	logic [31:0]   hno_q, e_hno, n_hno;
	logic [31:0]   hfw_q, e_hfw, n_hfw;
	logic [15:0]   nc_q, e_nc, n_nc;
	logic          halt_q, e_halt, n_halt;
	logic [31:0]   idx;
	logic          idx_small;

	function automatic logic [5:0] to_depth(input logic [NW-1:0] v);
		logic [NW+5:0] x;
		x = {6'd0, v};
		return x[5:0];
	endfunction

	always_comb begin
		// A first-byte mark restarts the walker before this byte is used.
		if (first_s1) begin
			e_phase = PH_TAG;
			e_lane  = '0;
			e_wg    = '0;
			e_nest  = '0;
			e_bl    = '0;
			e_hl    = '0;
			e_hno   = '0;
			e_hfw   = '0;
			e_nc    = '0;
			e_halt  = 1'b0;
		end else begin
			e_phase = phase_q;
			e_lane  = lane_q;
			e_wg    = wg_q;
			e_nest  = nest_q;
			e_bl    = bl_q;
			e_hl    = hl_q;
			e_hno   = hno_q;
			e_hfw   = hfw_q;
			e_nc    = nc_q;
			e_halt  = halt_q;
		end

		wg_shift  = {e_wg[23:0], data_s1};
		idx       = e_hl - e_bl;
		idx_small = (idx < 32'd4);
		bl_dec    = e_bl - 32'd1;

		n_phase = e_phase;
		n_lane  = e_lane;
		n_wg    = e_wg;
		n_nest  = e_nest;
		n_bl    = e_bl;
		n_hl    = e_hl;
		n_hno   = e_hno;
		n_hfw   = e_hfw;
		n_nc    = e_nc;
		n_halt  = e_halt;

		evt_valid            = 1'b0;
		evt                  = '0;
		evt.kind             = dttw_pkg::EV_NOP;
		evt.depth            = to_depth(e_nest);

		if (valid_s1 && !e_halt) begin
			n_lane = e_lane + 2'd1;
			case (e_phase)
				PH_TAG: begin
					n_wg = wg_shift;
					if (e_lane == 2'd3) begin
						if (wg_shift == dttw_pkg::TAG_BEGIN_NODE) begin
							n_nc    = '0;
							n_phase = PH_NAME;
						end else if (wg_shift == dttw_pkg::TAG_END_NODE) begin
							evt_valid = 1'b1;
							evt.kind  = dttw_pkg::EV_END_NODE;
							if (e_nest == '0) begin
								evt.depth_fault = 1'b1;
							end else begin
								n_nest    = e_nest - 1'b1;
								evt.depth = to_depth(e_nest - 1'b1);
							end
						end else if (wg_shift == dttw_pkg::TAG_PROP) begin
							n_phase = PH_PLEN;
						end else if (wg_shift == dttw_pkg::TAG_NOP) begin
							evt_valid = 1'b1;
							evt.kind  = dttw_pkg::EV_NOP;
						end else if (wg_shift == dttw_pkg::TAG_END) begin
							evt_valid = 1'b1;
							evt.kind  = dttw_pkg::EV_END;
							n_halt    = 1'b1;
						end else begin
							evt_valid = 1'b1;
							evt.kind  = dttw_pkg::EV_BAD_TAG;
							n_halt    = 1'b1;
						end
					end
				end
				PH_NAME: begin
					if (data_s1 == 8'd0) begin
						evt_valid            = 1'b1;
						evt.kind             = dttw_pkg::EV_BEGIN_NODE;
						evt.node_name_length = e_nc;
						if (e_nest >= NEST_MAX) begin
							n_nest          = NEST_MAX;
							evt.depth_fault = 1'b1;
						end else begin
							n_nest = e_nest + 1'b1;
						end
						n_phase = (e_lane == 2'd3) ? PH_TAG : PH_PAD;
					end else if (e_nc != 16'hFFFF) begin
						n_nc = e_nc + 16'd1;
					end
				end
				PH_PLEN: begin
					n_wg = wg_shift;
					if (e_lane == 2'd3) begin
						n_hl    = wg_shift;
						n_phase = PH_POFF;
					end
				end
				PH_POFF: begin
					n_wg = wg_shift;
					if (e_lane == 2'd3) begin
						n_hno = wg_shift;
						n_hfw = '0;
						n_bl  = e_hl;
						if (e_hl == '0) begin
							evt_valid       = 1'b1;
							evt.kind        = dttw_pkg::EV_PROP;
							evt.name_offset = wg_shift;
							n_phase         = PH_TAG;
						end else begin
							n_phase = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					if (idx_small) begin
						case (idx[1:0])
							2'd0:    n_hfw = e_hfw | {data_s1, 24'd0};
							2'd1:    n_hfw = e_hfw | {8'd0, data_s1, 16'd0};
							2'd2:    n_hfw = e_hfw | {16'd0, data_s1, 8'd0};
							default: n_hfw = e_hfw | {24'd0, data_s1};
						endcase
					end
					n_bl = bl_dec;
					// The event leaves once the first word is full or the payload ends.
					if (idx_small && (idx[1:0] == 2'd3 || bl_dec == '0)) begin
						evt_valid       = 1'b1;
						evt.kind        = dttw_pkg::EV_PROP;
						evt.prop_length = e_hl;
						evt.name_offset = e_hno;
						evt.first_word  = n_hfw;
					end
					if (bl_dec == '0) begin
						n_phase = (e_lane == 2'd3) ? PH_TAG : PH_PAD;
					end
				end
				PH_PAD: begin
					if (e_lane == 2'd3) begin
						n_phase = PH_TAG;
					end
				end
				default: begin
					n_phase = PH_TAG;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			lane_q  <= '0;
			wg_q    <= '0;
			nest_q  <= '0;
			bl_q    <= '0;
			hl_q    <= '0;
			hno_q   <= '0;
			hfw_q   <= '0;
			nc_q    <= '0;
			halt_q  <= 1'b0;
		end else if (valid_s1) begin
			phase_q <= n_phase;
			lane_q  <= n_lane;
			wg_q    <= n_wg;
			nest_q  <= n_nest;
			bl_q    <= n_bl;
			hl_q    <= n_hl;
			hno_q   <= n_hno;
			hfw_q   <= n_hfw;
			nc_q    <= n_nc;
			halt_q  <= n_halt;
		end
	end

endmodule

// ===== sv/dttw_evt_fifo.sv =====
// Small result queue that holds finished events until the output side takes them.
module dttw_evt_fifo (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        push,
	input  dttw_pkg::walk_event_t                       push_evt,
	input  logic                                        pop,
	output logic                                        head_valid,
	output dttw_pkg::walk_event_t                       head_evt,
	output logic [$clog2(dttw_pkg::EVT_FIFO_DEPTH+1)-1:0] count
);

	localparam int unsigned DEPTH = dttw_pkg::EVT_FIFO_DEPTH;
	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	dttw_pkg::walk_event_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign do_pop     = pop && (cnt_q != '0);
	assign head_valid = (cnt_q != '0);
	assign head_evt   = mem_q[rd_q];
	assign count      = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
